/* hdl/nfc_frame_to_key_events_macros.svh */
// Assertion macros shared by the frame-to-key-event block.
`ifndef NFC_FRAME_TO_KEY_EVENTS_MACROS_SVH
`define NFC_FRAME_TO_KEY_EVENTS_MACROS_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define NFC_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the block clock, off during reset.
`define NFC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/nfc_f2k_pkg.sv */
// Types and constants shared by the frame-to-key-event block.
`default_nettype none
package nfc_f2k_pkg;

   // Frame layout.
   localparam logic [7:0]  MAGIC_BYTE      = 8'hBC;
   localparam logic [7:0]  CARD_FRAME      = 8'hD5;
   localparam logic [7:0]  SUB_PRESENT     = 8'h00;
   localparam logic [7:0]  SUB_REMOVED     = 8'h01;
   localparam logic [7:0]  CRC_TYPE_MIN    = 8'h80;
   localparam logic [15:0] MIN_PRESENT_LEN = 16'd9;
   localparam int          POS_W           = 17;
   localparam logic [16:0] POS_TYPE        = 17'd3;
   localparam logic [16:0] POS_LEN_HI      = 17'd4;
   localparam logic [16:0] POS_LEN_LO      = 17'd5;
   localparam logic [16:0] HEADER_BYTES    = 17'd7;
   localparam logic [16:0] UID_FIRST       = 17'd9;
   localparam logic [16:0] UID_LAST        = 17'd15;
   localparam logic [16:0] CRC_TAIL        = 17'd4;

   // Widths of the configuration port and the table entries.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int UID_W       = 56;

   // Depths of the two queues.
   localparam int DESC_DEPTH = 2;
   localparam int EVT_DEPTH  = 2;

   // A finished card frame that needs action.
   typedef struct packed {
      logic             removed;
      logic [UID_W-1:0] uid;
   } desc_type;

   // One key event.
   typedef struct packed {
      logic [7:0] key_code;
      logic       key_pressed;
      logic       last_of_run;
   } evt_type;

endpackage
`default_nettype wire

/* hdl/nfc_f2k_fifo.sv */
// Small synchronous queue built from registers.
`default_nettype none
module nfc_f2k_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rdata,
   output logic                  empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == (AW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // Pointer and fill-count update, wrapping at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset; the count guards it.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule
`default_nettype wire

/* hdl/nfc_f2k_front.sv */
// Front end: tracks frame position, collects header fields and classifies frames.
`default_nettype none
module nfc_f2k_front
   import nfc_f2k_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] rx_byte,
   output logic            desc_push,
   output desc_type        desc_data
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       type_ff, type_in;
   logic [15:0]      len_ff, len_in;
   logic [7:0]       sub_ff, sub_in;
   logic [UID_W-1:0] uid_ff, uid_in;
   logic [POS_W-1:0] pos_inc;
   logic [POS_W-1:0] frame_len;
   logic             frame_done;
   logic             card_action;

   assign pos_inc   = pos_ff + 1'b1;
   assign frame_len = HEADER_BYTES + {1'b0, len_ff}
                      + ((type_ff >= CRC_TYPE_MIN) ? CRC_TAIL : '0);

   // Field capture and position tracking for each accepted byte.
   always_comb begin
      pos_in     = pos_ff;
      type_in    = type_ff;
      len_in     = len_ff;
      sub_in     = sub_ff;
      uid_in     = uid_ff;
      frame_done = 1'b0;
      if (accept) begin
         if (pos_ff == '0) begin
            // Hunting: only the magic byte starts a frame.
            if (rx_byte == MAGIC_BYTE) begin
               sub_in = '0;
               uid_in = '0;
               pos_in = POS_W'(1);
            end
         end else begin
            if (pos_ff == POS_TYPE) begin
               type_in = rx_byte;
            end else if (pos_ff == POS_LEN_HI) begin
               len_in = {rx_byte, len_ff[7:0]};
            end else if (pos_ff == POS_LEN_LO) begin
               len_in = {len_ff[15:8], rx_byte};
            end else if (pos_ff == HEADER_BYTES) begin
               sub_in = rx_byte;
            end else if (pos_ff inside {[UID_FIRST:UID_LAST]}) begin
               uid_in = {uid_ff[UID_W-9:0], rx_byte};
            end
            frame_done = (pos_inc >= HEADER_BYTES) && (pos_inc >= frame_len);
            pos_in     = frame_done ? '0 : pos_inc;
         end
      end
   end

   // Only card frames that remove a card or present a full UID need the back end.
   assign card_action = (type_ff == CARD_FRAME)
                        && ((sub_in == SUB_REMOVED)
                            || ((sub_in == SUB_PRESENT) && (len_ff >= MIN_PRESENT_LEN)));
   assign desc_push         = frame_done && card_action;
   assign desc_data.removed = (sub_in == SUB_REMOVED);
   assign desc_data.uid     = uid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         type_ff <= '0;
         len_ff  <= '0;
         sub_ff  <= '0;
         uid_ff  <= '0;
      end else begin
         pos_ff  <= pos_in;
         type_ff <= type_in;
         len_ff  <= len_in;
         sub_ff  <= sub_in;
         uid_ff  <= uid_in;
      end
   end

endmodule
`default_nettype wire

/* hdl/nfc_f2k_back.sv */
// Back end: tag table, UID lookup, held key and key event generation.
`default_nettype none
module nfc_f2k_back
   import nfc_f2k_pkg::*;
#(
   parameter int NUM_TAGS = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   desc_empty,
   input  desc_type                    desc_data,
   output logic                        desc_pop,
   input  wire logic                   evt_full,
   output logic                        evt_push,
   output evt_type                     evt_data
);

   logic [CSR_DATA_W-1:0] tag_ff [NUM_TAGS];
   logic [7:0]            held_ff, held_in;
   logic                  pend_valid_ff, pend_valid_in;
   evt_type               pend_ff, pend_in;
   logic                  hit;
   logic [7:0]            hit_key;
   logic                  rel_v, press_v;
   logic                  take;

   // Table writes; indexes past the table are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TAGS; i++) begin
            tag_ff[i] <= '0;
         end
      end else if (csr_we && (int'(csr_index) < NUM_TAGS)) begin
         tag_ff[csr_index] <= csr_wdata;
      end
   end

   // First-match search; lower entries win.
   always_comb begin
      hit     = 1'b0;
      hit_key = '0;
      for (int i = NUM_TAGS - 1; i >= 0; i--) begin
         if (tag_ff[i][CSR_DATA_W-1:8] == desc_data.uid) begin
            hit     = 1'b1;
            hit_key = tag_ff[i][7:0];
         end
      end
   end

   assign take = !desc_empty && !pend_valid_ff && !evt_full;
   assign desc_pop = take;

   // Decide the release and press for the frame at the head of the queue.
   always_comb begin
      rel_v   = 1'b0;
      press_v = 1'b0;
      held_in = held_ff;
      if (take) begin
         if (desc_data.removed) begin
            rel_v   = (held_ff != '0);
            held_in = '0;
         end else if (hit) begin
            rel_v   = (held_ff != '0) && (held_ff != hit_key);
            press_v = (hit_key != '0);
            held_in = hit_key;
         end
      end
   end

   // The first event goes out now; a press after a release waits in the pending register.
   always_comb begin
      evt_push      = 1'b0;
      evt_data      = pend_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (pend_valid_ff) begin
         if (!evt_full) begin
            evt_push      = 1'b1;
            pend_valid_in = 1'b0;
         end
      end else if (rel_v) begin
         evt_push             = 1'b1;
         evt_data.key_code    = held_ff;
         evt_data.key_pressed = 1'b0;
         evt_data.last_of_run = !press_v;
         pend_valid_in        = press_v;
         pend_in.key_code     = hit_key;
         pend_in.key_pressed  = 1'b1;
         pend_in.last_of_run  = 1'b1;
      end else if (press_v) begin
         evt_push             = 1'b1;
         evt_data.key_code    = hit_key;
         evt_data.key_pressed = 1'b1;
         evt_data.last_of_run = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         held_ff       <= held_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

endmodule
`default_nettype wire

/* hdl/nfc_frame_to_key_events.sv */
// Usage: bytes from an NFC reader's serial link come in on the request queue
// (push/full, req_rx_byte) and key events leave on the response queue
// (empty/pop, rsp_key_code, rsp_key_pressed, rsp_last_of_run).
// The tag table is loaded through csr_we/csr_index/csr_wdata while idle; a
// write takes effect at once and indexes past the table are dropped.
// Throughput: one byte per cycle while the frame queue has room. Only a byte
// that ends an actionable card frame puts a frame into the two-entry frame
// queue. The back end takes a frame only when no press is pending and the
// response queue has room, and writes one event per cycle into the two-entry
// response queue while it has room; a frame with a release and a press holds
// the back end until the press has left the pending register. The first event
// of a frame is registered in the frame queue and then in the response queue.
// When the receiver stops popping, the response queue fills, the back end
// holds its frame, the frame queue fills and full rises; no item is lost.
// Reset clears the frame position (hunting for magic), the held key, both
// queues and the tag table.
`default_nettype none
`include "nfc_frame_to_key_events_macros.svh"
module nfc_frame_to_key_events
   import nfc_f2k_pkg::*;
#(
   parameter int NUM_TAGS = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   output logic                        full,
   input  wire logic [7:0]             req_rx_byte,
   output logic                        empty,
   input  wire logic                   pop,
   output logic [7:0]                  rsp_key_code,
   output logic                        rsp_key_pressed,
   output logic                        rsp_last_of_run,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic     accept;
   logic     desc_push, desc_pop, desc_full, desc_empty;
   desc_type desc_wdata, desc_rdata;
   logic     evt_push, evt_full;
   evt_type  evt_wdata, evt_rdata;

   // A byte is taken whenever the frame queue has room.
   assign full   = desc_full;
   assign accept = push && !desc_full;

   nfc_f2k_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .desc_push (desc_push),
      .desc_data (desc_wdata)
   );

   nfc_f2k_fifo #(
      .WIDTH ($bits(desc_type)),
      .DEPTH (DESC_DEPTH)
   ) u_desc_q (
      .clock (clock),
      .reset (reset),
      .push  (desc_push),
      .wdata (desc_wdata),
      .full  (desc_full),
      .pop   (desc_pop),
      .rdata (desc_rdata),
      .empty (desc_empty)
   );

   nfc_f2k_back #(
      .NUM_TAGS (NUM_TAGS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .desc_empty (desc_empty),
      .desc_data  (desc_rdata),
      .desc_pop   (desc_pop),
      .evt_full   (evt_full),
      .evt_push   (evt_push),
      .evt_data   (evt_wdata)
   );

   nfc_f2k_fifo #(
      .WIDTH ($bits(evt_type)),
      .DEPTH (EVT_DEPTH)
   ) u_evt_q (
      .clock (clock),
      .reset (reset),
      .push  (evt_push),
      .wdata (evt_wdata),
      .full  (evt_full),
      .pop   (pop),
      .rdata (evt_rdata),
      .empty (empty)
   );

   assign rsp_key_code    = evt_rdata.key_code;
   assign rsp_key_pressed = evt_rdata.key_pressed;
   assign rsp_last_of_run = evt_rdata.last_of_run;

   // Checks on the internal queues and event content.
   `NFC_ASSERT_IMPLY(a_desc_no_overflow, desc_push, !desc_full, "frame queue overflow")
   `NFC_ASSERT_IMPLY(a_evt_no_overflow, evt_push, !evt_full, "event queue overflow")
   `NFC_ASSERT_IMPLY(a_evt_key_nonzero, evt_push, evt_wdata.key_code != 8'd0, "event for key zero")
   `NFC_ASSERT_IMPLY(a_first_is_release, evt_push && !evt_wdata.last_of_run, !evt_wdata.key_pressed, "first of two events is not a release")

endmodule
`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the NFC frame to key event block.
`timescale 1ns / 100ps

module tb_top;
   import nfc_f2k_pkg::*;

   localparam int TAG_SLOTS   = 8;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PHASE_BYTES = 160;
   localparam int SETTLE      = 8;

   // Card identities used by the directed frames.
   localparam logic [55:0] UID_ONES = 56'hFF_FFFF_FFFF_FFFF;
   localparam logic [55:0] UID_A    = 56'h04_A1B2_C3D4_E5F6;
   localparam logic [55:0] UID_B    = 56'h80_0102_0304_0506;
   localparam logic [55:0] UID_C    = 56'h1F_2E3D_4C5B_6A79;
   localparam logic [55:0] UID_D    = 56'h55_AA55_AA55_AA55;
   localparam logic [55:0] UID_E    = 56'h7E_0000_0000_00E7;
   localparam logic [55:0] UID_MISS = 56'h12_3456_789A_BCDE;

   typedef enum int {TABLE_RANDOM, TABLE_ZERO, TABLE_ONES} table_fill_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   push = 1'b0;
   logic                   full;
   logic [7:0]             req_rx_byte = '0;
   logic                   empty;
   logic                   pop = 1'b0;
   logic [7:0]             rsp_key_code;
   logic                   rsp_key_pressed;
   logic                   rsp_last_of_run;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Traffic shaping, shared between the test tasks and the receiver.
   int   send_idle_pct = 0;
   int   rcv_stall_pct = 0;
   logic hold_pop = 1'b0;
   int   cycle_count = 0;
   int   error_count = 0;

   // Mirror of the block: tag table, frame parser state and held key.
   logic [63:0] tag_table [TAG_SLOTS];
   logic [63:0] tag_plan [TAG_SLOTS];
   logic [16:0] frame_pos = '0;
   logic [7:0]  pred_type = '0;
   logic [15:0] pred_len = '0;
   logic [7:0]  pred_sub = '0;
   logic [55:0] pred_uid = '0;
   logic [7:0]  held_key = '0;
   evt_type     key_events_due [$];

   nfc_frame_to_key_events #(
      .NUM_TAGS(TAG_SLOTS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_rx_byte(req_rx_byte),
      .empty(empty),
      .pop(pop),
      .rsp_key_code(rsp_key_code),
      .rsp_key_pressed(rsp_key_pressed),
      .rsp_last_of_run(rsp_last_of_run),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
   endtask

   // Receiver: check each popped key event, then decide whether to pop next cycle.
   always @(posedge clock) begin
      evt_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (key_events_due.size() == 0) begin
               report_mismatch($sformatf("unexpected key event code %02h pressed %0b",
                                         rsp_key_code, rsp_key_pressed));
            end else begin
               want = key_events_due.pop_front();
               if (rsp_key_code !== want.key_code)
                  report_mismatch($sformatf("key_code %02h, expected %02h",
                                            rsp_key_code, want.key_code));
               if (rsp_key_pressed !== want.key_pressed)
                  report_mismatch($sformatf("key_pressed %0b, expected %0b for key %02h",
                                            rsp_key_pressed, want.key_pressed, want.key_code));
               if (rsp_last_of_run !== want.last_of_run)
                  report_mismatch($sformatf("last_of_run %0b, expected %0b for key %02h",
                                            rsp_last_of_run, want.last_of_run, want.key_code));
            end
         end
         pop <= !hold_pop && ($urandom_range(99) >= rcv_stall_pct);
      end
   end

   // Act on a completed frame: card removal or a tag table lookup.
   task automatic resolve_card_frame();
      int          first_new;
      logic        found;
      logic [7:0]  tag_key;
      evt_type     last_evt;
      first_new = key_events_due.size();
      found = 1'b0;
      if (pred_type == CARD_FRAME) begin
         if (pred_sub == SUB_REMOVED) begin
            if (held_key != 0) begin
               key_events_due.push_back('{key_code: held_key, key_pressed: 1'b0,
                                          last_of_run: 1'b0});
               held_key = '0;
            end
         end else if (pred_sub == SUB_PRESENT && pred_len >= MIN_PRESENT_LEN) begin
            for (int i = 0; i < TAG_SLOTS; i++) begin
               if (!found && tag_table[i][63:8] == pred_uid) begin
                  found = 1'b1;
                  tag_key = tag_table[i][7:0];
                  if (held_key != 0 && held_key != tag_key)
                     key_events_due.push_back('{key_code: held_key, key_pressed: 1'b0,
                                                last_of_run: 1'b0});
                  held_key = tag_key;
                  if (tag_key != 0)
                     key_events_due.push_back('{key_code: tag_key, key_pressed: 1'b1,
                                                last_of_run: 1'b0});
               end
            end
         end
      end
      // The final event of this byte carries the end-of-run flag.
      if (key_events_due.size() > first_new) begin
         last_evt = key_events_due.pop_back();
         last_evt.last_of_run = 1'b1;
         key_events_due.push_back(last_evt);
      end
   endtask

   // Track the frame parser for one accepted byte.
   task automatic predict_key_events(input logic [7:0] rx);
      logic [16:0] pos_next;
      logic [17:0] frame_len;
      if (frame_pos == 0) begin
         if (rx == MAGIC_BYTE) begin
            pred_sub = '0;
            pred_uid = '0;
            frame_pos = 17'd1;
         end
      end else begin
         if (frame_pos == POS_TYPE)
            pred_type = rx;
         else if (frame_pos == POS_LEN_HI)
            pred_len[15:8] = rx;
         else if (frame_pos == POS_LEN_LO)
            pred_len[7:0] = rx;
         else if (frame_pos == HEADER_BYTES)
            pred_sub = rx;
         else if (frame_pos >= UID_FIRST && frame_pos <= UID_LAST)
            pred_uid = {pred_uid[47:0], rx};
         pos_next = frame_pos + 17'd1;
         frame_len = HEADER_BYTES + pred_len + ((pred_type >= CRC_TYPE_MIN) ? CRC_TAIL : '0);
         if (pos_next >= HEADER_BYTES && pos_next >= frame_len) begin
            frame_pos = '0;
            resolve_card_frame();
         end else begin
            frame_pos = pos_next;
         end
      end
   endtask

   // Offer one byte, with an optional idle gap first, and wait until it is taken.
   task automatic send_byte(input logic [7:0] rx);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct)
            @(posedge clock);
      end
      push <= 1'b1;
      req_rx_byte <= rx;
      @(posedge clock);
      while (full)
         @(posedge clock);
      predict_key_events(rx);
   endtask

   // Send a whole frame: header, payload with subcommand and UID, and CRC tail for CRC types.
   task automatic send_frame(input logic [7:0] ftype, input logic [15:0] len,
                             input logic [7:0] sub, input logic [55:0] uid,
                             output int n_bytes);
      int stop;
      send_byte(MAGIC_BYTE);
      send_byte(8'($urandom_range(255)));
      send_byte(8'($urandom_range(255)));
      send_byte(ftype);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      send_byte(8'($urandom_range(255)));
      stop = 7 + int'(len);
      for (int p = 7; p < stop; p++) begin
         if (p == 7)
            send_byte(sub);
         else if (p >= 9 && p <= 15)
            send_byte(uid[(15 - p) * 8 +: 8]);
         else
            send_byte(8'($urandom_range(255)));
      end
      n_bytes = stop;
      if (ftype >= CRC_TYPE_MIN) begin
         repeat (4)
            send_byte(8'($urandom_range(255)));
         n_bytes += 4;
      end
   endtask

   // Stop offering items and let every expected key event come out.
   task automatic wait_drain();
      push <= 1'b0;
      while (key_events_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE)
         @(posedge clock);
   endtask

   // Load the planned table into the block, one register per cycle.
   task automatic write_tag_table();
      for (int i = 0; i < TAG_SLOTS; i++) begin
         csr_we <= 1'b1;
         csr_index <= CSR_INDEX_W'(i);
         csr_wdata <= tag_plan[i];
         @(posedge clock);
         tag_table[i] = tag_plan[i];
      end
      csr_we <= 1'b0;
   endtask

   task automatic test_directed_frames();
      int n;
      send_idle_pct = 0;
      rcv_stall_pct = 0;
      tag_plan[0] = {UID_ONES, 8'hFF};
      tag_plan[1] = {UID_A, 8'h04};
      tag_plan[2] = {UID_B, 8'h00};
      tag_plan[3] = {UID_A, 8'h22};
      tag_plan[4] = {UID_C, 8'h04};
      tag_plan[5] = {56'h0, 8'h01};
      tag_plan[6] = {UID_D, 8'h80};
      tag_plan[7] = {UID_E, 8'h7F};
      write_tag_table();
      // Bytes outside a frame are dropped.
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'hBD);
      send_byte(8'h5A);
      // A low type with no payload ends on the last header byte.
      send_frame(8'h00, 16'd0, SUB_PRESENT, UID_A, n);
      // A card frame with an empty body has no effect.
      send_frame(CARD_FRAME, 16'd0, SUB_PRESENT, UID_A, n);
      send_frame(CARD_FRAME, 16'd9, SUB_PRESENT, UID_ONES, n);
      // Duplicate UID: the first entry wins, the held key is released first.
      send_frame(CARD_FRAME, 16'd9, SUB_PRESENT, UID_A, n);
      // Same keycode as the held key: pressed again without a release.
      send_frame(CARD_FRAME, 16'd9, SUB_PRESENT, UID_C, n);
      // Entry with keycode zero: release only.
      send_frame(CARD_FRAME, 16'd9, SUB_PRESENT, UID_B, n);
      send_frame(CARD_FRAME, 16'd1, SUB_REMOVED, UID_A, n);
      send_frame(CARD_FRAME, 16'd9, SUB_PRESENT, UID_E, n);
      // Too short, unknown subcommand, unknown card, other types: no effect.
      send_frame(CARD_FRAME, 16'd8, SUB_PRESENT, UID_A, n);
      send_frame(CARD_FRAME, 16'd9, 8'h02, UID_A, n);
      send_frame(CARD_FRAME, 16'd9, SUB_PRESENT, UID_MISS, n);
      send_frame(8'h7F, 16'd9, SUB_PRESENT, UID_A, n);
      send_frame(8'hD4, 16'd9, SUB_PRESENT, UID_A, n);
      // A longer payload with an all-zero UID.
      send_frame(CARD_FRAME, 16'd20, SUB_PRESENT, 56'h0, n);
      send_frame(CARD_FRAME, 16'd1, SUB_REMOVED, UID_A, n);
      send_frame(CARD_FRAME, 16'd1, SUB_REMOVED, UID_A, n);
      wait_drain();
   endtask

   // Receiver holds off for a long stretch while frames keep coming in.
   task automatic test_backpressure();
      int n;
      send_idle_pct = 0;
      rcv_stall_pct = 0;
      fork
         begin
            hold_pop <= 1'b1;
            repeat (400)
               @(posedge clock);
            hold_pop <= 1'b0;
         end
      join_none
      repeat (8) begin
         send_frame(CARD_FRAME, 16'd9, SUB_PRESENT, UID_A, n);
         send_frame(CARD_FRAME, 16'd9, SUB_PRESENT, UID_ONES, n);
         send_frame(CARD_FRAME, 16'd1, SUB_REMOVED, UID_B, n);
      end
      wait_drain();
   endtask

   // A payload length that uses both bytes of the length field.
   task automatic test_longest_frame();
      int n;
      send_idle_pct = 0;
      rcv_stall_pct = 0;
      send_frame(CARD_FRAME, 16'h0123, SUB_PRESENT, UID_D, n);
      send_frame(CARD_FRAME, 16'd9, SUB_PRESENT, UID_A, n);
      wait_drain();
   endtask

   // Mostly well-formed card frames with random content, plus noise and other types.
   task automatic test_random_traffic(input table_fill_type fill, input int idle_pct,
                                      input int stall_pct);
      int          sent;
      int          n;
      int          pick;
      int          idx;
      logic [7:0]  ftype;
      logic [7:0]  rx;
      logic [15:0] len;
      logic [55:0] uid;
      send_idle_pct = idle_pct;
      rcv_stall_pct = stall_pct;
      // Build a table: all zero, all ones, or random with duplicated UIDs and shared or zero keycodes common.
      for (int i = 0; i < TAG_SLOTS; i++) begin
         case (fill)
            TABLE_ZERO: tag_plan[i] = '0;
            TABLE_ONES: tag_plan[i] = '1;
            default: begin
               idx = $urandom_range(i);
               uid = (i > 0 && $urandom_range(3) == 0) ? tag_plan[idx][63:8] :
                     56'({$urandom(), $urandom()});
               if ($urandom_range(4) == 0)
                  tag_plan[i] = {uid, 8'h00};
               else if (i > 0 && $urandom_range(3) == 0)
                  tag_plan[i] = {uid, tag_plan[idx][7:0]};
               else
                  tag_plan[i] = {uid, 8'($urandom_range(1, 255))};
            end
         endcase
      end
      write_tag_table();
      sent = 0;
      while (sent < PHASE_BYTES) begin
         pick = $urandom_range(99);
         idx = $urandom_range(TAG_SLOTS - 1);
         uid = ($urandom_range(4) == 0) ? 56'({$urandom(), $urandom()}) : tag_table[idx][63:8];
         if (pick < 45) begin
            len = ($urandom_range(3) == 0) ? 16'($urandom_range(10, 21)) : 16'd9;
            send_frame(CARD_FRAME, len, SUB_PRESENT, uid, n);
         end else if (pick < 65) begin
            send_frame(CARD_FRAME, 16'($urandom_range(1, 4)), SUB_REMOVED, uid, n);
         end else if (pick < 75) begin
            if ($urandom_range(1) == 1)
               send_frame(CARD_FRAME, 16'($urandom_range(1, 12)), 8'($urandom_range(2, 255)),
                          uid, n);
            else
               send_frame(CARD_FRAME, 16'($urandom_range(8)), SUB_PRESENT, uid, n);
         end else if (pick < 88) begin
            ftype = 8'($urandom_range(255));
            if (ftype == CARD_FRAME)
               ftype = 8'h55;
            len = ($urandom_range(9) == 0) ? 16'($urandom_range(13, 300)) :
                  16'($urandom_range(12));
            send_frame(ftype, len, 8'($urandom_range(1)), uid, n);
         end else begin
            // Line noise between frames, never the magic byte.
            n = $urandom_range(1, 5);
            repeat (n) begin
               rx = 8'($urandom_range(255));
               if (rx == MAGIC_BYTE)
                  rx = ~rx;
               send_byte(rx);
            end
         end
         sent += n;
      end
      wait_drain();
   endtask

   initial begin
      repeat (12)
         @(posedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_backpressure();
      test_longest_frame();
      test_random_traffic(TABLE_RANDOM, 0, 0);
      test_random_traffic(TABLE_ZERO, 46, 0);
      test_random_traffic(TABLE_RANDOM, 0, 46);
      test_random_traffic(TABLE_ONES, 24, 24);
      test_random_traffic(TABLE_RANDOM, 24, 24);
      wait_drain();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+hdl
hdl/nfc_f2k_pkg.sv
hdl/nfc_f2k_fifo.sv
hdl/nfc_f2k_front.sv
hdl/nfc_f2k_back.sv
hdl/nfc_frame_to_key_events.sv
sim/tb_top.sv
